@@ rtl/core/tdrr_pkg.sv @@
package tdrr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_REPLAY_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAW_OPEN_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAW_CLOSED_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH     = 3'd4;

    localparam logic [6:0]         DEAD_BAND_RST     = 7'd5;
    localparam logic signed [12:0] CLAW_OPEN_RST     = 13'sd107;
    localparam logic signed [12:0] CLAW_CLOSED_RST   = 13'sd10;
    localparam logic [10:0]        RECORD_LENGTH_RST = 11'd700;

    // motor commands (arm and claw)
    localparam logic [1:0] CMD_STOP = 2'd0;
    localparam logic [1:0] CMD_FWD  = 2'd1;
    localparam logic [1:0] CMD_REV  = 2'd2;

    // phase codes as reported on the output
    localparam logic [1:0] PHASE_CODE_DRIVER = 2'd0;
    localparam logic [1:0] PHASE_CODE_RECORD = 2'd1;
    localparam logic [1:0] PHASE_CODE_REPLAY = 2'd2;
    localparam logic [1:0] PHASE_CODE_DONE   = 2'd3;

    typedef enum logic [3:0] {
        PH_DRIVER = 4'b0001,
        PH_RECORD = 4'b0010,
        PH_REPLAY = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    // input word, first field in the high bits
    typedef struct packed {
        logic signed [12:0] claw_angle;
        logic               record_button;
        logic               arm_down_button;
        logic               arm_up_button;
        logic               claw_toggle_button;
        logic signed [7:0]  fast_drive_axis;
        logic signed [7:0]  slow_drive_axis;
        logic signed [7:0]  fast_turn_axis;
        logic signed [7:0]  slow_turn_axis;
    } t_in_item;

    localparam int IN_W  = $bits(t_in_item);

    // one entry of the command store
    typedef struct packed {
        logic              claw_flag;
        logic [1:0]        arm;
        logic signed [7:0] right;
        logic signed [7:0] left;
    } t_entry;

    typedef struct packed {
        t_phase             phase_now;
        logic signed [12:0] claw_angle;
        t_entry             cmd;
    } t_s0;

    typedef struct packed {
        logic signed [12:0] open_limit;
        logic signed [12:0] closed_limit;
    } t_limits;

    // output word, first field in the high bits
    typedef struct packed {
        logic [1:0]        phase_now;
        logic              commands_valid;
        logic [1:0]        claw_command;
        logic [1:0]        arm_command;
        logic signed [7:0] right_velocity;
        logic signed [7:0] left_velocity;
    } t_out_item;

    localparam int OUT_W = $bits(t_out_item);

    function automatic logic [1:0] f_phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_DRIVER: code = PHASE_CODE_DRIVER;
            PH_RECORD: code = PHASE_CODE_RECORD;
            PH_REPLAY: code = PHASE_CODE_REPLAY;
            PH_DONE:   code = PHASE_CODE_DONE;
            default:   code = PHASE_CODE_DRIVER;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/tdrr_store.sv @@
module tdrr_store
    import tdrr_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [STORE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tdrr_ctrl.sv @@
module tdrr_ctrl
    import tdrr_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    localparam int AW = $clog2(STORE_DEPTH),
    localparam int TW = $clog2(STORE_DEPTH + 1),
    localparam int LW = (TW > 11) ? TW : 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  t_in_item              i_item,
    output t_s0                   o_s0,
    output t_limits               o_limits,
    output logic                  o_mem_we,
    output logic                  o_mem_re,
    output logic [AW-1:0]         o_mem_addr,
    output t_entry                o_mem_wdata
);

    logic [6:0]         r_dead_band;
    logic signed [12:0] r_open_limit;
    logic signed [12:0] r_closed_limit;
    logic [10:0]        r_record_length;

    t_phase        r_phase, n_phase;
    logic [TW-1:0] r_tick, n_tick;
    logic          r_claw_flag, n_claw_flag;
    logic          r_toggle_prev, n_toggle_prev;

    logic              driving;
    logic              flag_new;
    logic [1:0]        arm;
    logic signed [7:0] left, right;
    logic [AW-1:0]     idx;
    logic [TW-1:0]     tick_inc;
    logic [LW-1:0]     len_ext, eff_len;
    logic              at_end;
    t_entry            entry;

    function automatic logic [7:0] f_mag(input logic signed [7:0] v);
        return v[7] ? 8'(-v) : 8'(v);
    endfunction

    // truncating divide by 3 via reciprocal 171/512, exact for |v| <= 128
    function automatic logic signed [7:0] f_div3(input logic signed [7:0] v);
        logic [7:0]  m;
        logic [15:0] p;
        logic [7:0]  q;
        m = f_mag(v);
        p = 16'(m) * 16'd171;
        q = 8'(p >> 9);
        return v[7] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [7:0] f_sat(input logic signed [8:0] v);
        logic signed [7:0] s;
        if (v > 9'sd127) begin
            s = 8'sd127;
        end else if (v < -9'sd127) begin
            s = -8'sd127;
        end else begin
            s = v[7:0];
        end
        return s;
    endfunction

    assign driving = (r_phase == PH_DRIVER) || (r_phase == PH_RECORD);
    assign flag_new = (i_item.claw_toggle_button && !r_toggle_prev) ? ~r_claw_flag
                                                                    : r_claw_flag;

    always_comb begin
        priority if (i_item.arm_up_button) begin
            arm = CMD_FWD;
        end else if (i_item.arm_down_button) begin
            arm = CMD_REV;
        end else begin
            arm = CMD_STOP;
        end
    end

    always_comb begin
        priority if (f_mag(i_item.slow_drive_axis) > {1'b0, r_dead_band}) begin
            left  = f_div3(i_item.slow_drive_axis);
            right = left;
        end else if (f_mag(i_item.slow_turn_axis) > {1'b0, r_dead_band}) begin
            left  = f_div3(i_item.slow_turn_axis);
            right = -left;
        end else if (f_mag(i_item.fast_drive_axis) > {1'b0, r_dead_band}) begin
            left  = f_sat({i_item.fast_drive_axis[7], i_item.fast_drive_axis});
            right = left;
        end else if (f_mag(i_item.fast_turn_axis) > {1'b0, r_dead_band}) begin
            left  = f_sat({i_item.fast_turn_axis[7], i_item.fast_turn_axis});
            right = f_sat(-{i_item.fast_turn_axis[7], i_item.fast_turn_axis});
        end else begin
            left  = 8'sd0;
            right = 8'sd0;
        end
    end

    assign entry = '{claw_flag: flag_new, arm: arm, right: right, left: left};

    // tick never reaches the depth in an active phase; guard keeps the index in range
    assign idx      = (r_tick < TW'(STORE_DEPTH)) ? r_tick[AW-1:0] : '0;
    assign tick_inc = TW'(idx) + TW'(1);
    assign len_ext  = LW'(r_record_length);
    assign eff_len  = (len_ext == '0) ? LW'(1)
                    : ((len_ext > LW'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : len_ext);
    assign at_end   = LW'(tick_inc) >= eff_len;

    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_claw_flag   = r_claw_flag;
        n_toggle_prev = r_toggle_prev;
        priority if (i_cfg_we && (i_cfg_addr == CFG_REPLAY_MODE)) begin
            n_phase     = i_cfg_wdata[0] ? PH_REPLAY : PH_DRIVER;
            n_tick      = '0;
            n_claw_flag = 1'b0;
        end else if (i_accept) begin
            if (driving) begin
                n_claw_flag   = flag_new;
                n_toggle_prev = i_item.claw_toggle_button;
            end
            unique case (r_phase)
                PH_DRIVER: begin
                    if (i_item.record_button) begin
                        n_tick  = '0;
                        n_phase = PH_RECORD;
                    end
                end
                PH_RECORD: begin
                    n_tick = tick_inc;
                    if (at_end) begin
                        n_phase = PH_DRIVER;
                    end
                end
                PH_REPLAY: begin
                    n_tick = tick_inc;
                    if (at_end) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_DRIVER;
            r_tick        <= '0;
            r_claw_flag   <= 1'b0;
            r_toggle_prev <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_claw_flag   <= n_claw_flag;
            r_toggle_prev <= n_toggle_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_band     <= DEAD_BAND_RST;
            r_open_limit    <= CLAW_OPEN_RST;
            r_closed_limit  <= CLAW_CLOSED_RST;
            r_record_length <= RECORD_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEAD_BAND:         r_dead_band     <= i_cfg_wdata[6:0];
                CFG_CLAW_OPEN_LIMIT:   r_open_limit    <= $signed(i_cfg_wdata);
                CFG_CLAW_CLOSED_LIMIT: r_closed_limit  <= $signed(i_cfg_wdata);
                CFG_RECORD_LENGTH:     r_record_length <= i_cfg_wdata[10:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s0.phase_now  = r_phase;
    assign o_s0.claw_angle = i_item.claw_angle;
    assign o_s0.cmd        = entry;

    assign o_limits.open_limit   = r_open_limit;
    assign o_limits.closed_limit = r_closed_limit;

    assign o_mem_we    = i_accept && (r_phase == PH_RECORD);
    assign o_mem_re    = i_accept && (r_phase == PH_REPLAY);
    assign o_mem_addr  = idx;
    assign o_mem_wdata = entry;

endmodule

@@ rtl/core/tdrr_out.sv @@
module tdrr_out
    import tdrr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_s0       i_s0,
    input  t_entry    i_mem_rdata,
    input  t_limits   i_limits,
    input  logic      i_m_tready,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    output t_out_item o_m_item
);

    logic      r_s1_valid;
    t_s0       r_s1;
    logic      r_o_valid;
    t_out_item r_o_item;

    logic      s1_move;
    t_entry    cmd;
    logic [1:0] claw;
    t_out_item n_o_item;

    assign s1_move    = r_s1_valid && (!r_o_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_move;

    // replayed ticks take their commands from the store read issued at accept
    assign cmd = (r_s1.phase_now == PH_REPLAY) ? i_mem_rdata : r_s1.cmd;

    always_comb begin
        if (cmd.claw_flag) begin
            claw = (r_s1.claw_angle < i_limits.open_limit) ? CMD_FWD : CMD_STOP;
        end else begin
            claw = (r_s1.claw_angle > i_limits.closed_limit) ? CMD_REV : CMD_STOP;
        end
    end

    always_comb begin
        n_o_item.phase_now = f_phase_code(r_s1.phase_now);
        if (r_s1.phase_now == PH_DONE) begin
            n_o_item.commands_valid = 1'b0;
            n_o_item.claw_command   = CMD_STOP;
            n_o_item.arm_command    = CMD_STOP;
            n_o_item.right_velocity = 8'sd0;
            n_o_item.left_velocity  = 8'sd0;
        end else begin
            n_o_item.commands_valid = 1'b1;
            n_o_item.claw_command   = claw;
            n_o_item.arm_command    = cmd.arm;
            n_o_item.right_velocity = cmd.right;
            n_o_item.left_velocity  = cmd.left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_s0;
        end
        if (s1_move) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_item   = r_o_item;

endmodule

@@ rtl/core/teleop_drive_record_replay.sv @@
// Drive, arm and claw command generator with record and replay, one word per control tick.
// Input stream (s_axis): one word per tick with the four stick axes, four buttons and the
// measured claw angle. Output stream (m_axis): one word per input word with both drive
// velocities, arm and claw commands, a commands-valid flag and the phase the tick ran in.
// Configuration: write enable, register index and data; the user must write only while
// no word is in flight, which the block does not enforce. Writing replay_mode restarts at
// driver (0) or replay (1) from store entry 0. An accepted word is held in the middle
// stage register, then loaded into the output register once that register is free.
// Throughput: one word per cycle while m_axis is not stalled. Phase, tick index and claw
// flag update at the accept edge; the command store is read at that edge and its registered
// data is used by the middle stage, so successive ticks never wait on one another.
// Recording writes one store entry per tick; replay reads back entries in order.
// When the receiver stalls the output register holds its word, one more word waits in
// the middle stage, and s_axis_tready falls once both are full.
// Reset (synchronous, active low) returns to driver phase, clears the tick index and claw
// flag and loads the register defaults. The command store is not cleared.
module teleop_drive_record_replay
    import tdrr_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // slow_turn_axis, fast_turn_axis, slow_drive_axis, fast_drive_axis,
    // claw_toggle_button, arm_up_button, arm_down_button, record_button, claw_angle
    input  logic [55:0]           i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // left_velocity, right_velocity, arm_command, claw_command, commands_valid, phase_now
    output logic [23:0]           o_m_axis_tdata
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic          accept;
    t_in_item      item;
    t_s0           s0;
    t_limits       limits;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    t_entry        mem_wdata, mem_rdata;
    t_out_item     out_item;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign item   = t_in_item'(i_s_axis_tdata[IN_W-1:0]);

    tdrr_ctrl #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (accept),
        .i_item     (item),
        .o_s0       (s0),
        .o_limits   (limits),
        .o_mem_we   (mem_we),
        .o_mem_re   (mem_re),
        .o_mem_addr (mem_addr),
        .o_mem_wdata(mem_wdata)
    );

    tdrr_store #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_addr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_addr),
        .o_rdata(mem_rdata)
    );

    tdrr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_s0       (s0),
        .i_mem_rdata(mem_rdata),
        .i_limits   (limits),
        .i_m_tready (i_m_axis_tready),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_item   (out_item)
    );

    assign o_m_axis_tdata = {(24 - OUT_W)'(0), out_item};

endmodule

@@ bench/tb_teleop_drive_record_replay.sv @@
module tb_teleop_drive_record_replay;
    import tdrr_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int SLOW_DIV  = 3;
    localparam int HOLD_LONG = 300;
    localparam int N_TICKS   = 1650;

    // button masks for the directed ticks: {record, down, up, claw toggle}
    localparam logic [3:0] B_CLAW = 4'b0001;
    localparam logic [3:0] B_UP   = 4'b0010;
    localparam logic [3:0] B_DOWN = 4'b0100;
    localparam logic [3:0] B_REC  = 4'b1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // slow_turn_axis, fast_turn_axis, slow_drive_axis, fast_drive_axis,
    // claw_toggle_button, arm_up_button, arm_down_button, record_button, claw_angle
    logic [55:0]           i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // left_velocity, right_velocity, arm_command, claw_command, commands_valid, phase_now
    logic [23:0]           o_m_axis_tdata;

    teleop_drive_record_replay #(
        .STORE_DEPTH(DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // shadow of the block: registers
    logic [6:0]          cfg_dead_band  = DEAD_BAND_RST;
    logic signed [12:0]  cfg_open_lim   = CLAW_OPEN_RST;
    logic signed [12:0]  cfg_closed_lim = CLAW_CLOSED_RST;
    logic [10:0]         cfg_rec_len    = RECORD_LENGTH_RST;

    // shadow of the block: state
    logic [1:0] ph          = PHASE_CODE_DRIVER;
    int         tick_idx    = 0;
    logic       claw_open   = 1'b0;
    logic       toggle_prev = 1'b0;
    t_entry     cmd_store [DEPTH];
    bit         recorded  [DEPTH];

    t_in_item   tick_q[$];
    t_out_item  cmd_due_q[$];

    int  n_err = 0;
    int  n_sent = 0;
    int  n_out = 0;
    bit  in_taken = 1'b0;
    bit  src_idle_on = 1'b1;
    bit  snk_idle_on = 1'b1;
    int  src_gap = 0;
    int  snk_stall = 0;
    int  hold_req = 0;
    int  hold_seen = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clip_pct(int v);
        if (v > 127) return 127;
        if (v < -127) return -127;
        return v;
    endfunction

    function automatic int play_len();
        int n;
        n = cfg_rec_len;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    function automatic logic [1:0] claw_drive(logic is_open, int ang);
        if (is_open) return (ang < int'(cfg_open_lim)) ? CMD_FWD : CMD_STOP;
        return (ang > int'(cfg_closed_lim)) ? CMD_REV : CMD_STOP;
    endfunction

    // one tick through the shadow state; returns the command word it must produce
    function automatic t_out_item compute_commands(t_in_item w);
        int         sy, sx, fy, fx, ang, db, lv, rv, slot;
        logic [1:0] arm, claw, now;
        logic       valid;
        t_entry     e;
        t_out_item  r;
        sy = $signed(w.slow_drive_axis);
        sx = $signed(w.slow_turn_axis);
        fy = $signed(w.fast_drive_axis);
        fx = $signed(w.fast_turn_axis);
        ang = $signed(w.claw_angle);
        db = cfg_dead_band;
        lv = 0;
        rv = 0;
        arm = CMD_STOP;
        claw = CMD_STOP;
        valid = 1'b1;
        now = ph;
        slot = tick_idx % DEPTH;
        if (now == PHASE_CODE_DRIVER || now == PHASE_CODE_RECORD) begin
            if (w.claw_toggle_button) begin
                if (!toggle_prev) claw_open = !claw_open;
                toggle_prev = 1'b1;
            end else begin
                toggle_prev = 1'b0;
            end
            arm = w.arm_up_button ? CMD_FWD : (w.arm_down_button ? CMD_REV : CMD_STOP);
            claw = claw_drive(claw_open, ang);
            if (magnitude(sy) > db) begin
                lv = sy / SLOW_DIV;
                rv = lv;
            end else if (magnitude(sx) > db) begin
                lv = sx / SLOW_DIV;
                rv = -lv;
            end else if (magnitude(fy) > db) begin
                lv = fy;
                rv = fy;
            end else if (magnitude(fx) > db) begin
                lv = fx;
                rv = -fx;
            end
            lv = clip_pct(lv);
            rv = clip_pct(rv);
            if (now == PHASE_CODE_DRIVER) begin
                if (w.record_button) begin
                    tick_idx = 0;
                    ph = PHASE_CODE_RECORD;
                end
            end else begin
                e.left = lv[7:0];
                e.right = rv[7:0];
                e.arm = arm;
                e.claw_flag = claw_open;
                cmd_store[slot] = e;
                recorded[slot] = 1'b1;
                tick_idx = slot + 1;
                if (tick_idx >= play_len()) ph = PHASE_CODE_DRIVER;
            end
        end else if (now == PHASE_CODE_REPLAY) begin
            e = cmd_store[slot];
            lv = $signed(e.left);
            rv = $signed(e.right);
            arm = e.arm;
            claw = claw_drive(e.claw_flag, ang);
            tick_idx = slot + 1;
            if (tick_idx >= play_len()) ph = PHASE_CODE_DONE;
        end else begin
            valid = 1'b0;
        end
        r.left_velocity = lv[7:0];
        r.right_velocity = rv[7:0];
        r.arm_command = arm;
        r.claw_command = claw;
        r.commands_valid = valid;
        r.phase_now = now;
        return r;
    endfunction

    task automatic flag_error(string msg);
        n_err++;
        if (n_err <= 10) $display("%s", msg);
    endtask

    // sender: one word offered at a time, random gaps between words
    always @(negedge i_clk) begin
        t_in_item w;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || in_taken) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    w = tick_q.pop_front();
                    i_s_axis_tdata <= {{(56-IN_W){1'b0}}, w};
                    i_s_axis_tvalid <= 1'b1;
                    src_gap = pick_gap(src_idle_on);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            snk_stall = HOLD_LONG;
        end
        if (snk_stall > 0) begin
            snk_stall = snk_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            snk_stall = pick_gap(snk_idle_on);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready)
                cmd_due_q.push_back(compute_commands(i_s_axis_tdata[IN_W-1:0]));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[OUT_W-1:0];
                n_out++;
                if (cmd_due_q.size() == 0) begin
                    flag_error($sformatf("word %0d: unexpected result %h", n_out, got));
                end else begin
                    want = cmd_due_q.pop_front();
                    if (got.left_velocity !== want.left_velocity
                            || got.right_velocity !== want.right_velocity
                            || got.arm_command !== want.arm_command
                            || got.claw_command !== want.claw_command
                            || got.commands_valid !== want.commands_valid
                            || got.phase_now !== want.phase_now)
                        flag_error($sformatf({"word %0d: exp L%0d R%0d arm%0d claw%0d",
                            " v%0d ph%0d / got L%0d R%0d arm%0d claw%0d v%0d ph%0d"},
                            n_out, $signed(want.left_velocity),
                            $signed(want.right_velocity), want.arm_command,
                            want.claw_command, want.commands_valid, want.phase_now,
                            $signed(got.left_velocity), $signed(got.right_velocity),
                            got.arm_command, got.claw_command, got.commands_valid,
                            got.phase_now));
                end
            end
        end
    end

    function automatic int pick_gap(bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [7:0] random_axis();
        int db, v;
        db = cfg_dead_band;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = int'($urandom_range(0, 2 * db)) - db;
            5, 6:          v = int'($urandom_range(0, 200)) - 100;
            7:             v = $urandom_range(0, 255);
            8:             v = $urandom_range(0, 1) ? db + 1 : -db - 1;
            default:       v = $urandom_range(0, 1) ? 127 : -128;
        endcase
        return v[7:0];
    endfunction

    function automatic logic signed [12:0] random_angle();
        int v;
        case ($urandom_range(0, 9))
            0:       v = -4096;
            1:       v = 4095;
            2:       v = $urandom_range(0, 8191);
            3, 4:    v = int'(cfg_open_lim) + int'($urandom_range(0, 4)) - 2;
            5, 6:    v = int'(cfg_closed_lim) + int'($urandom_range(0, 4)) - 2;
            default: v = int'($urandom_range(0, 300)) - 100;
        endcase
        return v[12:0];
    endfunction

    function automatic t_in_item random_tick(logic rec);
        t_in_item w;
        w.slow_turn_axis = random_axis();
        w.fast_turn_axis = random_axis();
        w.slow_drive_axis = random_axis();
        w.fast_drive_axis = random_axis();
        w.claw_toggle_button = $urandom_range(0, 1);
        w.arm_up_button = $urandom_range(0, 2) == 0;
        w.arm_down_button = $urandom_range(0, 1);
        w.record_button = rec;
        w.claw_angle = random_angle();
        return w;
    endfunction

    function automatic t_in_item tick_of(int sx, int fx, int sy, int fy,
                                         logic [3:0] btn, int ang);
        t_in_item w;
        w.slow_turn_axis = sx[7:0];
        w.fast_turn_axis = fx[7:0];
        w.slow_drive_axis = sy[7:0];
        w.fast_drive_axis = fy[7:0];
        w.claw_toggle_button = btn[0];
        w.arm_up_button = btn[1];
        w.arm_down_button = btn[2];
        w.record_button = btn[3];
        w.claw_angle = ang[12:0];
        return w;
    endfunction

    function automatic int pick_limit(int center);
        case ($urandom_range(0, 5))
            0:       return -4096;
            1:       return 4095;
            2:       return $urandom_range(0, 8191);
            default: return center + int'($urandom_range(0, 80)) - 40;
        endcase
    endfunction

    function automatic int stored_prefix();
        int n;
        n = 0;
        while (n < DEPTH && recorded[n]) n++;
        return n;
    endfunction

    task automatic push_tick(t_in_item w);
        tick_q.push_back(w);
        n_sent++;
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || i_s_axis_tvalid || cmd_due_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        logic [CFG_DATA_W-1:0] d;
        d = value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        case (idx)
            CFG_REPLAY_MODE: begin
                tick_idx = 0;
                claw_open = 1'b0;
                ph = d[0] ? PHASE_CODE_REPLAY : PHASE_CODE_DRIVER;
            end
            CFG_DEAD_BAND:         cfg_dead_band = d[6:0];
            CFG_CLAW_OPEN_LIMIT:   cfg_open_lim = d;
            CFG_CLAW_CLOSED_LIMIT: cfg_closed_lim = d;
            CFG_RECORD_LENGTH:     cfg_rec_len = d[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int n_phase, prefix, len, val, r;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: mixing priority, dead band edges, saturation, arm, claw toggling
        push_tick(tick_of(0, 0, 0, 0, 4'b0, 0));
        push_tick(tick_of(0, 0, 100, 0, 4'b0, 11));
        push_tick(tick_of(0, 0, -100, 0, 4'b0, 10));
        push_tick(tick_of(0, 0, 6, 127, 4'b0, -4096));
        push_tick(tick_of(0, 0, 5, -128, 4'b0, 4095));
        push_tick(tick_of(-100, 0, -5, 0, 4'b0, 9));
        push_tick(tick_of(7, -128, 0, 0, 4'b0, 0));
        push_tick(tick_of(5, -128, 0, 5, 4'b0, 0));
        push_tick(tick_of(0, 127, 0, -6, 4'b0, 0));
        push_tick(tick_of(0, 127, 0, 0, B_UP | B_DOWN, 0));
        push_tick(tick_of(-6, 0, 0, 0, B_DOWN, 0));
        push_tick(tick_of(0, 0, 0, 0, B_CLAW, 106));
        push_tick(tick_of(0, 0, 0, 0, B_CLAW, 107));
        push_tick(tick_of(0, 0, 0, 0, 4'b0, -4096));
        push_tick(tick_of(0, 0, 0, 0, B_CLAW, 4095));
        push_tick(tick_of(0, 0, 0, 0, 4'b0, 4095));
        wait_drained();

        // short recording, then replay it until done
        write_reg(CFG_RECORD_LENGTH, 3);
        push_tick(tick_of(0, 0, 40, 0, B_REC | B_CLAW, 50));
        push_tick(tick_of(0, 0, -90, 0, B_UP, 200));
        push_tick(tick_of(30, 0, 0, 0, B_REC | B_CLAW, 5));
        push_tick(tick_of(0, -128, 0, 0, B_DOWN, 0));
        push_tick(tick_of(0, 0, 0, 60, 4'b0, 0));
        wait_drained();
        write_reg(CFG_REPLAY_MODE, 1);
        push_tick(tick_of(0, 0, 100, 0, B_CLAW | B_UP, 0));
        push_tick(tick_of(100, 0, 0, 0, B_REC, 106));
        push_tick(tick_of(0, 0, 0, 0, B_DOWN, 107));
        push_tick(tick_of(0, 0, 0, 0, B_CLAW, 0));
        push_tick(tick_of(0, 100, 0, 0, B_CLAW | B_REC, 4095));
        wait_drained();

        n_phase = 0;
        while (n_sent < N_TICKS) begin
            n_phase++;
            src_idle_on = $urandom_range(0, 3) != 0;
            snk_idle_on = $urandom_range(0, 3) != 0;
            prefix = stored_prefix();
            if (n_phase == 4) begin
                // full-depth recording; receiver holds off while words keep coming
                src_idle_on = 1'b0;
                write_reg(CFG_RECORD_LENGTH, 2047);
                write_reg(CFG_REPLAY_MODE, 0);
                push_tick(random_tick(1'b1));
                repeat (DEPTH) push_tick(random_tick($urandom_range(0, 1)));
                push_tick(random_tick(1'b0));
                hold_req++;
            end else if (n_phase > 2 && prefix > 0 && $urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, (prefix < 40) ? prefix : 40);
                val = (len == 1 && $urandom_range(0, 1)) ? 0 : len;
                write_reg(CFG_RECORD_LENGTH, val);
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_CLAW_OPEN_LIMIT, pick_limit(107));
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_CLAW_CLOSED_LIMIT, pick_limit(10));
                write_reg(CFG_REPLAY_MODE, 1);
                repeat (len + $urandom_range(0, 3))
                    push_tick(random_tick($urandom_range(0, 1)));
            end else begin
                if (n_phase <= 2) begin
                    // register extremes early on
                    write_reg(CFG_DEAD_BAND, (n_phase == 1) ? 0 : 127);
                    write_reg(CFG_CLAW_OPEN_LIMIT, (n_phase == 1) ? 4095 : -4096);
                    write_reg(CFG_CLAW_CLOSED_LIMIT, (n_phase == 1) ? -4096 : 4095);
                end else begin
                    if ($urandom_range(0, 2) == 0) begin
                        r = $urandom_range(0, 5);
                        val = (r == 0) ? 0 : (r == 1) ? 100 : (r == 2) ? 127 :
                              (r == 3) ? 5 : $urandom_range(0, 127);
                        write_reg(CFG_DEAD_BAND, val);
                    end
                    if ($urandom_range(0, 2) == 0)
                        write_reg(CFG_CLAW_OPEN_LIMIT, pick_limit(107));
                    if ($urandom_range(0, 2) == 0)
                        write_reg(CFG_CLAW_CLOSED_LIMIT, pick_limit(10));
                end
                r = $urandom_range(0, 9);
                val = (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 30);
                len = (val == 0) ? 1 : val;
                write_reg(CFG_RECORD_LENGTH, val);
                write_reg(CFG_REPLAY_MODE, 0);
                if ($urandom_range(0, 4) == 0) begin
                    // noise: record presses anywhere
                    repeat ($urandom_range(5, 30))
                        push_tick(random_tick($urandom_range(0, 3) == 0));
                end else begin
                    repeat ($urandom_range(0, 4)) push_tick(random_tick(1'b0));
                    push_tick(random_tick(1'b1));
                    repeat (len) push_tick(random_tick($urandom_range(0, 1)));
                    repeat ($urandom_range(0, 3)) push_tick(random_tick(1'b0));
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
